[sv/fnci_pkg.sv]
// Shared types and constants for the four-neighbor color interpolator.
package fnci_pkg;

  // Configuration register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam int unsigned REG_W = 13;
  localparam logic [REG_W-1:0] IMAGE_SIZE_RESET = 13'h1000;

  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned NUM_CHANS = 4;
  localparam int unsigned NUM_CORNERS = 4;

  typedef struct packed {
    logic [19:0] x_position;
    logic [19:0] y_position;
    logic [31:0] pixel_top_left;
    logic [31:0] pixel_top_right;
    logic [31:0] pixel_bottom_right;
    logic [31:0] pixel_bottom_left;
  } in_item_t;

  typedef struct packed {
    logic [31:0] blended_color;
    logic        no_weight;
  } out_item_t;

endpackage

[sv/four_neighbor_color_interpolator_unit.sv]
// Top level: inverse-distance weighted blend of four ARGB corner pixels.
//
//  channel | direction | signals                          | payload
//  --------+-----------+----------------------------------+------------------
//  in      | to block  | in_valid_i, in_stall_o           | fnci_pkg::in_item_t
//  out     | from block| out_valid_o, out_stall_i         | fnci_pkg::out_item_t
//  cfg     | to block  | cfg_we_i, cfg_index_i, cfg_data_i | 13-bit image size
//
// One item per cycle unless the output is held. The squares are registered
// first, then the square-root pipes, the weight and sum stages and the
// quotient pipes follow. The whole pipe advances together; it holds only
// while the output register is full and stalled. Reset clears the valid
// bits and restores both image sizes to 4096.
module four_neighbor_color_interpolator_unit #(
  parameter int unsigned COORD_INT_BITS  = 12,
  parameter int unsigned COORD_FRAC_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  fnci_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output fnci_pkg::out_item_t  out_item_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [fnci_pkg::REG_W-1:0] cfg_data_i
);

  localparam int unsigned F    = COORD_FRAC_BITS;
  localparam int unsigned IB   = COORD_INT_BITS;
  localparam int unsigned CXW  = IB + F;
  localparam int unsigned CW   = (IB + 1 > fnci_pkg::REG_W) ? IB + 1 : fnci_pkg::REG_W;
  localparam int unsigned SQW  = 2 * F + 2;
  localparam int unsigned DW   = F + 1;
  localparam int unsigned WW   = 3 * F + 3;
  localparam int unsigned TW   = 3 * F + 5;
  localparam int unsigned NW   = 3 * F + 13;
  localparam int unsigned NC   = fnci_pkg::NUM_CORNERS;
  localparam int unsigned NCH  = fnci_pkg::NUM_CHANS;
  localparam int unsigned CHW  = fnci_pkg::CHAN_W;
  localparam int unsigned NS   = F + 1;
  localparam int unsigned NQ   = fnci_pkg::CHAN_W;
  localparam int unsigned LAT  = NS + 12;

  // Configuration registers
  logic [fnci_pkg::REG_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= fnci_pkg::IMAGE_SIZE_RESET;
      height_q <= fnci_pkg::IMAGE_SIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fnci_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data_i;
        fnci_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pipe control: everything advances unless the output is held
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en          = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // Stage 0: offsets, squared distances, bounds mask
  logic [CXW-1:0] x, y;
  logic [IB-1:0]  ix, iy;
  logic [DW-1:0]  fx, fy, gx, gy;
  logic [CW-1:0]  cx0, cx1, cy0, cy1, wlim, hlim;
  logic [SQW-1:0] sq_d [NC];
  logic [NC-1:0]  mask_d;
  logic [31:0]    pix_d [NC];

  always_comb begin
    x    = CXW'(in_item_i.x_position);
    y    = CXW'(in_item_i.y_position);
    ix   = x[CXW-1:F];
    iy   = y[CXW-1:F];
    fx   = DW'(x[F-1:0]);
    fy   = DW'(y[F-1:0]);
    gx   = (DW'(1) << F) - fx;
    gy   = (DW'(1) << F) - fy;
    cx0  = CW'(ix);
    cx1  = CW'(ix) + CW'(1);
    cy0  = CW'(iy);
    cy1  = CW'(iy) + CW'(1);
    wlim = CW'(width_q);
    hlim = CW'(height_q);
    sq_d[0] = SQW'(fx) * SQW'(fx) + SQW'(fy) * SQW'(fy);
    sq_d[1] = SQW'(gx) * SQW'(gx) + SQW'(fy) * SQW'(fy);
    sq_d[2] = SQW'(gx) * SQW'(gx) + SQW'(gy) * SQW'(gy);
    sq_d[3] = SQW'(fx) * SQW'(fx) + SQW'(gy) * SQW'(gy);
    mask_d[0] = (cx0 < wlim) && (cy0 < hlim);
    mask_d[1] = (cx1 < wlim) && (cy0 < hlim);
    mask_d[2] = (cx1 < wlim) && (cy1 < hlim);
    mask_d[3] = (cx0 < wlim) && (cy1 < hlim);
    pix_d[0] = in_item_i.pixel_top_left;
    pix_d[1] = in_item_i.pixel_top_right;
    pix_d[2] = in_item_i.pixel_bottom_right;
    pix_d[3] = in_item_i.pixel_bottom_left;
  end

  logic [SQW-1:0] sq_q   [NC];
  logic [NC-1:0]  mask_q [NS+1];
  logic [31:0]    pix_q  [NS+1][NC];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q      <= sq_d;
      mask_q[0] <= mask_d;
      pix_q[0]  <= pix_d;
      for (int s = 1; s <= NS; s++) begin
        mask_q[s] <= mask_q[s-1];
        pix_q[s]  <= pix_q[s-1];
      end
    end
  end

  // Distance lanes, one per corner
  logic [DW-1:0] corner_dist [NC];

  for (genvar i = 0; i < NC; i++) begin : g_dist
    fnci_sqrt_pipe #(.FRAC_BITS(F)) u_sqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .sq_i   (sq_q[i]),
      .root_o (corner_dist[i])
    );
  end

  // Stage A: pair products
  logic [2*DW-1:0] p01_q, p23_q;
  logic [DW-1:0]   da_q [NC];
  logic [NC-1:0]   mask_a_q;
  logic [31:0]     pix_a_q [NC];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p01_q    <= corner_dist[0] * corner_dist[1];
      p23_q    <= corner_dist[2] * corner_dist[3];
      da_q     <= corner_dist;
      mask_a_q <= mask_q[NS];
      pix_a_q  <= pix_q[NS];
    end
  end

  // Stage B: corner weights, product of the other three distances
  logic [WW-1:0] w_d [NC];
  logic [WW-1:0] w_q [NC];
  logic [31:0]   pix_b_q [NC];

  always_comb begin
    w_d[0] = mask_a_q[0] ? WW'(p23_q) * WW'(da_q[1]) : '0;
    w_d[1] = mask_a_q[1] ? WW'(p23_q) * WW'(da_q[0]) : '0;
    w_d[2] = mask_a_q[2] ? WW'(p01_q) * WW'(da_q[3]) : '0;
    w_d[3] = mask_a_q[3] ? WW'(p01_q) * WW'(da_q[2]) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w_q     <= w_d;
      pix_b_q <= pix_a_q;
    end
  end

  // Stage C: merge the corner lanes into total and per-channel sums
  logic [TW-1:0] total_d;
  logic [NW-1:0] sum_d [NCH];
  logic [TW-1:0] total_q;
  logic [NW-1:0] sum_q [NCH];
  logic          zero_q [NQ+1];

  always_comb begin
    total_d = '0;
    for (int i = 0; i < NC; i++) begin
      total_d = total_d + TW'(w_q[i]);
    end
    for (int c = 0; c < NCH; c++) begin
      sum_d[c] = '0;
      for (int i = 0; i < NC; i++) begin
        sum_d[c] = sum_d[c] + NW'(w_q[i]) * NW'(pix_b_q[i][CHW*c +: CHW]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      total_q   <= total_d;
      sum_q     <= sum_d;
      zero_q[0] <= (total_d == '0);
      for (int s = 1; s <= NQ; s++) begin
        zero_q[s] <= zero_q[s-1];
      end
    end
  end

  // Quotient lanes, one per color channel
  logic [CHW-1:0] quo [NCH];

  for (genvar c = 0; c < NCH; c++) begin : g_div
    fnci_div_pipe #(.FRAC_BITS(F)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (sum_q[c]),
      .den_i (total_q),
      .quo_o (quo[c])
    );
  end

  // Output: last divider stage is the output register
  always_comb begin
    out_item_o.no_weight = zero_q[NQ];
    for (int c = 0; c < NCH; c++) begin
      out_item_o.blended_color[CHW*c +: CHW] = zero_q[NQ] ? '0 : quo[c];
    end
  end

endmodule

[sv/fnci_sqrt_pipe.sv]
// Pipelined integer square root, one root bit per stage.
module fnci_sqrt_pipe #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [2*FRAC_BITS+1:0] sq_i,
  output logic [FRAC_BITS:0]     root_o
);

  localparam int unsigned NS  = FRAC_BITS + 1;
  localparam int unsigned SQW = 2 * FRAC_BITS + 2;
  localparam int unsigned RTW = FRAC_BITS + 1;
  localparam int unsigned RW  = FRAC_BITS + 4;

  logic [RTW-1:0] root_q [NS];
  logic [RW-1:0]  rem_q  [NS];
  logic [SQW-1:0] rad_q  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [RTW-1:0] prt;
    logic [RW-1:0]  prem;
    logic [SQW-1:0] prad;
    logic [RW-1:0]  cur, trial;
    logic [RTW-1:0] root_d;
    logic [RW-1:0]  rem_d;

    if (k == 0) begin : g_first
      assign prt  = '0;
      assign prem = '0;
      assign prad = sq_i;
    end else begin : g_next
      assign prt  = root_q[k-1];
      assign prem = rem_q[k-1];
      assign prad = rad_q[k-1];
    end

    // bring down two radicand bits and try the next root bit
    always_comb begin
      cur   = {prem[RW-3:0], prad[SQW-1 -: 2]};
      trial = {1'b0, prt, 2'b01};
      if (cur >= trial) begin
        rem_d  = cur - trial;
        root_d = {prt[RTW-2:0], 1'b1};
      end else begin
        rem_d  = cur;
        root_d = {prt[RTW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= root_d;
        rem_q[k]  <= rem_d;
        rad_q[k]  <= {prad[SQW-3:0], 2'b00};
      end
    end
  end

  assign root_o = root_q[NS-1];

endmodule

[sv/fnci_div_pipe.sv]
// Pipelined restoring divider, one bit of the 8-bit quotient per stage.
module fnci_div_pipe #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic [3*FRAC_BITS+12:0] num_i,
  input  logic [3*FRAC_BITS+4:0]  den_i,
  output logic [fnci_pkg::CHAN_W-1:0] quo_o
);

  localparam int unsigned NW = 3 * FRAC_BITS + 13;
  localparam int unsigned TW = 3 * FRAC_BITS + 5;
  localparam int unsigned QW = fnci_pkg::CHAN_W;

  logic [NW-1:0] rem_q [QW];
  logic [TW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [NW-1:0] prem, shd, rem_d;
    logic [TW-1:0] pden;
    logic [QW-1:0] pquo, quo_d;

    if (k == 0) begin : g_first
      assign prem = num_i;
      assign pden = den_i;
      assign pquo = '0;
    end else begin : g_next
      assign prem = rem_q[k-1];
      assign pden = den_q[k-1];
      assign pquo = quo_q[k-1];
    end

    // compare against divisor shifted to this quotient bit
    always_comb begin
      shd   = NW'(pden) << (QW - 1 - k);
      rem_d = prem;
      quo_d = pquo;
      if (prem >= shd) begin
        rem_d = prem - shd;
        quo_d[QW-1-k] = 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        den_q[k] <= pden;
        quo_q[k] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

[sv/fnci_checker.sv]
// Port-level assertions for the interpolator, bound to the top level.
module fnci_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input fnci_pkg::out_item_t out_item_o
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled result changed");

  // zero total weight forces a black result
  a_no_weight_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.no_weight) |-> (out_item_o.blended_color == '0))
    else $error("no_weight result carries color");

  // input backpressure only comes from a held full output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  // an unstalled result leaves or is replaced; the pipe never stalls then
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("pipe held while output free");

endmodule

bind four_neighbor_color_interpolator_unit fnci_checker u_fnci_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

[dv/testbench.sv]
// Testbench for the four-neighbor color interpolator: a scoreboard of predicted blends.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned FRAC = 8;
  localparam int unsigned INTB = 12;
  localparam int unsigned LATENCY = FRAC + 13;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  fnci_pkg::in_item_t in_item;
  logic out_valid;
  logic out_stall;
  fnci_pkg::out_item_t out_item;
  logic cfg_we;
  logic cfg_index;
  logic [fnci_pkg::REG_W-1:0] cfg_data;

  int unsigned cycle_cnt = 0;
  int unsigned fail_cnt = 0;
  int unsigned long_hold;
  logic hold_req;
  logic hold_taken;

  task automatic report_mismatch(string what, fnci_pkg::out_item_t exp_item,
                                 fnci_pkg::out_item_t got);
    $display("MISMATCH %s at cycle %0d: expected %h/%b got %h/%b", what, cycle_cnt,
             exp_item.blended_color, exp_item.no_weight, got.blended_color, got.no_weight);
    fail_cnt++;
  endtask

  // Predicted blends, oldest first
  class blend_scoreboard;
    fnci_pkg::out_item_t pending_blends[$];
    logic [fnci_pkg::REG_W-1:0] width_reg;
    logic [fnci_pkg::REG_W-1:0] height_reg;

    function new();
      width_reg = fnci_pkg::IMAGE_SIZE_RESET;
      height_reg = fnci_pkg::IMAGE_SIZE_RESET;
    endfunction

    // Integer square root by binary digit recurrence
    function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function automatic fnci_pkg::out_item_t blend(fnci_pkg::in_item_t it);
      longint unsigned x, y, ix, iy, fx, fy, gx, gy, total, w;
      longint unsigned cx[4], cy[4], corner_dist[4];
      longint unsigned sum[4];
      logic [31:0] pix[4];
      fnci_pkg::out_item_t r;
      x = it.x_position & ((64'd1 << (INTB + FRAC)) - 1);
      y = it.y_position & ((64'd1 << (INTB + FRAC)) - 1);
      ix = x >> FRAC;
      iy = y >> FRAC;
      fx = x & ((64'd1 << FRAC) - 1);
      fy = y & ((64'd1 << FRAC) - 1);
      gx = (64'd1 << FRAC) - fx;
      gy = (64'd1 << FRAC) - fy;
      cx[0] = ix;     cy[0] = iy;
      cx[1] = ix + 1; cy[1] = iy;
      cx[2] = ix + 1; cy[2] = iy + 1;
      cx[3] = ix;     cy[3] = iy + 1;
      pix[0] = it.pixel_top_left;
      pix[1] = it.pixel_top_right;
      pix[2] = it.pixel_bottom_right;
      pix[3] = it.pixel_bottom_left;
      corner_dist[0] = int_sqrt(fx * fx + fy * fy);
      corner_dist[1] = int_sqrt(gx * gx + fy * fy);
      corner_dist[2] = int_sqrt(gx * gx + gy * gy);
      corner_dist[3] = int_sqrt(fx * fx + gy * gy);
      total = 0;
      for (int c = 0; c < 4; c++) sum[c] = 0;
      for (int i = 0; i < 4; i++) begin
        if (cx[i] < width_reg && cy[i] < height_reg) begin
          w = 1;
          for (int j = 0; j < 4; j++) if (j != i) w = w * corner_dist[j];
          total += w;
          for (int c = 0; c < 4; c++) sum[c] += w * pix[i][8*c +: 8];
        end
      end
      r = '0;
      if (total == 0) begin
        r.no_weight = 1'b1;
      end else begin
        for (int c = 0; c < 4; c++) r.blended_color[8*c +: 8] = 8'(sum[c] / total);
      end
      return r;
    endfunction

    function void note_input(fnci_pkg::in_item_t it);
      pending_blends.push_back(blend(it));
    endfunction

    task check_result(fnci_pkg::out_item_t got);
      fnci_pkg::out_item_t exp_item;
      if (pending_blends.size() == 0) begin
        report_mismatch("result with nothing expected", '0, got);
        return;
      end
      exp_item = pending_blends.pop_front();
      if (got.blended_color !== exp_item.blended_color)
        report_mismatch("blended_color", exp_item, got);
      if (got.no_weight !== exp_item.no_weight)
        report_mismatch("no_weight", exp_item, got);
    endtask
  endclass

  blend_scoreboard sb;

  four_neighbor_color_interpolator_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Cycle watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: random stall pattern with a periodic stall-free window, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      long_hold <= 0;
      hold_taken <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      long_hold <= 199;
      out_stall <= 1'b1;
    end else if (long_hold != 0) begin
      long_hold <= long_hold - 1;
      out_stall <= 1'b1;
    end else if (cycle_cnt[9:7] == 3'd5) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // Output monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_item);
  end

  task automatic write_reg(logic idx, logic [fnci_pkg::REG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == fnci_pkg::REG_IMAGE_WIDTH) sb.width_reg = val;
    else sb.height_reg = val;
  endtask

  task automatic drain();
    while (sb.pending_blends.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Offer one item and hold it until the transfer
  task automatic send_item(fnci_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic idle(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic fnci_pkg::in_item_t rand_item(bit small_img);
    fnci_pkg::in_item_t it;
    it.pixel_top_left = $urandom();
    it.pixel_top_right = $urandom();
    it.pixel_bottom_right = $urandom();
    it.pixel_bottom_left = $urandom();
    it.x_position = 20'($urandom());
    it.y_position = 20'($urandom());
    if (small_img) begin
      it.x_position[19:12] = 8'd0;
      it.y_position[19:12] = 8'd0;
    end
    // Fractions on the grid now and then, to land on a grid line or a corner
    if ($urandom_range(0, 7) == 0) it.x_position[7:0] = 8'd0;
    if ($urandom_range(0, 7) == 0) it.y_position[7:0] = 8'd0;
    return it;
  endfunction

  function automatic fnci_pkg::in_item_t make_item(logic [19:0] x, logic [19:0] y);
    fnci_pkg::in_item_t it;
    it = rand_item(1'b0);
    it.x_position = x;
    it.y_position = y;
    return it;
  endfunction

  task automatic random_phase(int unsigned count, bit small_img);
    int unsigned sent;
    sent = 0;
    while (sent < count) begin
      for (int unsigned b = $urandom_range(1, 40); b > 0 && sent < count; b--) begin
        send_item(rand_item(small_img));
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 6));
    end
    in_valid <= 1'b0;
  endtask

  logic [fnci_pkg::REG_W-1:0] widths[6] =
    '{13'd4096, 13'd1, 13'd0, 13'd8191, 13'd16, 13'd4095};
  logic [fnci_pkg::REG_W-1:0] heights[6] =
    '{13'd4096, 13'd0, 13'd1, 13'd8191, 13'd15, 13'd2};

  initial begin
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_index = fnci_pkg::REG_IMAGE_WIDTH;
    cfg_data = '0;
    hold_req = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: corners, extremes, edges of the image
    send_item(make_item(20'h0, 20'h0));
    send_item(make_item(20'h00080, 20'h00080));
    send_item(make_item(20'hFFFFF, 20'hFFFFF));
    send_item(make_item(20'hFFF00, 20'h00000));
    send_item(make_item(20'h00000, 20'hFFF00));
    send_item(make_item(20'h000FF, 20'h000FF));
    send_item(make_item(20'h00001, 20'h00000));
    send_item(make_item(20'hAAAAA, 20'h55555));
    send_item(make_item(20'h55555, 20'hAAAAA));
    begin
      fnci_pkg::in_item_t it;
      it = make_item(20'h00040, 20'h000C0);
      it.pixel_top_left = '1; it.pixel_top_right = '1;
      it.pixel_bottom_right = '1; it.pixel_bottom_left = '1;
      send_item(it);
      it.pixel_top_left = '0; it.pixel_top_right = '0;
      it.pixel_bottom_right = '0; it.pixel_bottom_left = '0;
      send_item(it);
    end
    in_valid <= 1'b0;
    drain();

    // Long receiver hold-off while the sender keeps offering
    hold_req = 1'b1;
    random_phase(100, 1'b0);
    drain();

    // Random phases over several image sizes
    for (int p = 0; p < 6; p++) begin
      write_reg(fnci_pkg::REG_IMAGE_WIDTH, widths[p]);
      write_reg(fnci_pkg::REG_IMAGE_HEIGHT, heights[p]);
      send_item(make_item(20'h0, 20'h0));
      send_item(make_item({8'd0, 12'hF80}, {8'd0, 12'h140}));
      random_phase(300, p != 0);
      drain();
    end

    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
